// ----- rtl/rdc_pkg.sv -----
// rdc_pkg: shared types, constants and helper functions of the radix digit converter
// used by rdc_divider, rdc_digit_stack and radix_digit_converter
package rdc_pkg;

	localparam int VALUE_WIDTH = 31;
	localparam int DIGIT_W     = 6;
	localparam int CHAR_W      = 7;
	localparam int RADIX_W     = 6;
	localparam int MAX_DIGITS  = VALUE_WIDTH;
	localparam int STK_CNT_W   = $clog2(MAX_DIGITS + 1);
	localparam int STK_IDX_W   = $clog2(MAX_DIGITS);
	localparam int DIV_CNT_W   = $clog2(VALUE_WIDTH);
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(2);
	localparam logic [DIGIT_W-1:0] DIGIT_NINE  = DIGIT_W'(9);
	localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0]  ASCII_A     = 7'h41;
	localparam logic [CHAR_W-1:0]  ALPHA_BASE  = 7'd10;

	// register word index, taken from paddr[2]
	localparam logic REG_RADIX = 1'b0;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV_START,
		S_DIV_WAIT,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic empty;
		logic last;
	} stack_stat_t;

	function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		res = r;
		if (r < RADIX_MIN)
			res = RADIX_MIN;
		else if (r > RADIX_MAX)
			res = RADIX_MAX;
		return res;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] res;
		if (d <= DIGIT_NINE)
			res = ASCII_ZERO + CHAR_W'(d);
		else
			res = ASCII_A + (CHAR_W'(d) - ALPHA_BASE);
		return res;
	endfunction

endpackage

// ----- rtl/radix_digit_converter.sv -----
// radix_digit_converter: value to base-2..36 ascii digits, most significant first
// each digit takes one pass through the shared divider (load, 31 bit steps, result), then
// digits leave one beat per cycle while out_stall is low; a zero value skips the divider
// one value at a time: in_stall stays high until the last digit has entered the output register
// reset: arst_n asynchronous, radix returns to 2, output and digit stack empty
module radix_digit_converter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [rdc_pkg::PADDR_W-1:0]      paddr,
	input  logic [rdc_pkg::PDATA_W-1:0]      pwdata,
	output logic [rdc_pkg::PDATA_W-1:0]      prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [rdc_pkg::VALUE_WIDTH-1:0]  value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [rdc_pkg::CHAR_W-1:0]       digit_char,
	output logic                             last_digit
);
	import rdc_pkg::*;

	state_t state_q, state_d;

	logic [RADIX_W-1:0]     radix_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic                   out_valid_q;
	logic [CHAR_W-1:0]      char_q;
	logic                   last_q;

	logic                   in_acc;
	logic                   div_start;
	logic                   div_done;
	logic [VALUE_WIDTH-1:0] quot;
	logic [DIGIT_W-1:0]     rem;
	logic                   push;
	logic [DIGIT_W-1:0]     push_data;
	logic                   pop;
	logic [DIGIT_W-1:0]     top_data;
	stack_stat_t            stk;

	// config port
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_RADIX)) begin
			radix_q <= pwdata[RADIX_W-1:0];
		end
	end
	assign prdata = (paddr[2] == REG_RADIX) ? PDATA_W'(radix_q) : '0;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;

	rdc_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (value_q),
		.divisor   (eff_radix(radix_q)),
		.done      (div_done),
		.quotient  (quot),
		.remainder (rem)
	);

	rdc_digit_stack u_stk (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.top_data  (top_data),
		.stat      (stk)
	);

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		push      = 1'b0;
		push_data = rem;
		pop       = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (value == '0) begin
						// zero still gives one digit
						push      = 1'b1;
						push_data = '0;
						state_d   = S_EMIT;
					end else begin
						state_d = S_DIV_START;
					end
				end
			end
			S_DIV_START: begin
				div_start = 1'b1;
				state_d   = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (div_done) begin
					push    = 1'b1;
					state_d = (quot == '0) ? S_EMIT : S_DIV_START;
				end
			end
			S_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					pop = 1'b1;
					if (stk.last)
						state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			value_q <= value;
		else if (div_done && state_q == S_DIV_WAIT)
			value_q <= quot;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			char_q <= digit_to_ascii(top_data);
			last_q <= stk.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign digit_char = char_q;
	assign last_digit = last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> stk.empty)
		else $error("new value accepted with digits left over");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> !stk.empty)
		else $error("emitting from an empty digit stack");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV_WAIT))
		else $error("divider result outside wait state");

	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && stk.last) |=> (state_q == S_IDLE && last_digit))
		else $error("last digit not flagged at end of run");

endmodule

// ----- rtl/rdc_divider.sv -----
// rdc_divider: restoring divider, one quotient bit per cycle
// divides a VALUE_WIDTH dividend by a 6-bit divisor; depends on rdc_pkg
module rdc_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [rdc_pkg::VALUE_WIDTH-1:0] dividend,
	input  logic [rdc_pkg::RADIX_W-1:0]     divisor,
	output logic                           done,
	output logic [rdc_pkg::VALUE_WIDTH-1:0] quotient,
	output logic [rdc_pkg::DIGIT_W-1:0]     remainder
);
	import rdc_pkg::*;

	logic [VALUE_WIDTH-1:0] dvd_q;
	logic [DIGIT_W-1:0]     rem_q;
	logic [RADIX_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic                   busy_q;
	logic                   done_q;

	logic [DIGIT_W:0] shifted;
	logic [DIGIT_W:0] diff;
	logic             ge;

	assign shifted = {rem_q, dvd_q[VALUE_WIDTH-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign ge      = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start)
				busy_q <= 1'b1;
			else if (busy_q && (cnt_q == '0))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
			cnt_q <= DIV_CNT_W'(VALUE_WIDTH - 1);
		end else if (busy_q) begin
			dvd_q <= {dvd_q[VALUE_WIDTH-2:0], ge};
			rem_q <= ge ? diff[DIGIT_W-1:0] : shifted[DIGIT_W-1:0];
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

	// the partial remainder stays below the divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (remainder < dvs_q))
		else $error("divider remainder not below divisor");

	assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("divider did not start");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy_q)
		else $error("divider done while busy");

endmodule

// ----- rtl/rdc_digit_stack.sv -----
// rdc_digit_stack: last-in first-out store of digits, reverses remainder order
// depends on rdc_pkg
module rdc_digit_stack (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [rdc_pkg::DIGIT_W-1:0] push_data,
	input  logic                       pop,
	output logic [rdc_pkg::DIGIT_W-1:0] top_data,
	output rdc_pkg::stack_stat_t        stat
);
	import rdc_pkg::*;

	logic [DIGIT_W-1:0]   mem [MAX_DIGITS];
	logic [STK_CNT_W-1:0] cnt_q;
	logic [STK_CNT_W-1:0] cnt_d;
	logic [STK_CNT_W-1:0] nxt_top;
	logic [DIGIT_W-1:0]   top_q;

	always_comb begin
		cnt_d = cnt_q;
		if (push)
			cnt_d = cnt_q + 1'b1;
		else if (pop)
			cnt_d = cnt_q - 1'b1;
	end

	assign nxt_top = cnt_d - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[cnt_q[STK_IDX_W-1:0]] <= push_data;
	end

	// top entry is registered ahead of use from the next count, a push forwards its digit
	always_ff @(posedge clk) begin
		if (push)
			top_q <= push_data;
		else if (cnt_d != '0)
			top_q <= mem[nxt_top[STK_IDX_W-1:0]];
	end

	assign top_data   = top_q;
	assign stat.empty = (cnt_q == '0);
	assign stat.last  = (cnt_q == STK_CNT_W'(1));

	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < STK_CNT_W'(MAX_DIGITS)))
		else $error("digit stack overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("digit stack underflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !pop)
		else $error("digit stack push and pop together");

endmodule

// ----- tb/tb.sv -----
// tb: self-checking bench for radix_digit_converter, value in, ascii digits out msb first
// depends on rdc_pkg for port widths; predicts digits from its own radix shadow register
`timescale 1ns / 100ps

module tb;

	localparam int VW = rdc_pkg::VALUE_WIDTH;
	localparam int CW = rdc_pkg::CHAR_W;
	localparam int AW = rdc_pkg::PADDR_W;
	localparam int DW = rdc_pkg::PDATA_W;

	localparam logic [AW-1:0] ADDR_RADIX = AW'(0);
	localparam logic [AW-1:0] ADDR_SPARE = AW'(4);
	localparam int BASE_LO     = 2;
	localparam int BASE_HI     = 36;
	localparam int QUIET_LIMIT = 5000;
	localparam int REPORT_MAX  = 10;

	typedef struct packed {
		logic [CW-1:0] ch;
		logic          last;
	} digit_beat_t;

	logic          clk;
	logic          arst_n;
	logic          psel, penable, pwrite;
	logic [AW-1:0] paddr;
	logic [DW-1:0] pwdata, prdata;
	logic          pready;
	logic          in_valid, in_stall;
	logic [VW-1:0] value;
	logic          out_valid, out_stall;
	logic [CW-1:0] digit_char;
	logic          last_digit;

	digit_beat_t   pending_digits[$];
	digit_beat_t   want;
	logic [5:0]    radix_shadow;
	bit            idle_on;
	int            mismatches;
	int            values_sent;
	int            beats_checked;
	int            radix_writes;
	int            quiet_cycles;
	int            hold_left;
	bit            hold_stall;

	radix_digit_converter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.digit_char(digit_char),
		.last_digit(last_digit)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// expected digits of one value under the current radix, msd first
	function automatic void predict_digits(input logic [VW-1:0] v);
		int unsigned   base;
		int unsigned   rem;
		logic [VW-1:0] q;
		logic [CW-1:0] chars[$];
		digit_beat_t   b;
		if (radix_shadow < BASE_LO)
			base = BASE_LO;
		else if (radix_shadow > BASE_HI)
			base = BASE_HI;
		else
			base = radix_shadow;
		q = v;
		// do-while gives the single '0' for a zero value
		do begin
			rem = q % base;
			q = VW'(q / base);
			chars.push_front(rem < 10 ? CW'("0" + rem) : CW'("A" + rem - 10));
		end while (q != 0);
		foreach (chars[i]) begin
			b.ch = chars[i];
			b.last = (i == chars.size() - 1);
			pending_digits.push_back(b);
		end
	endfunction

	function automatic logic [VW-1:0] pick_value();
		longint unsigned p;
		int unsigned     base;
		int              k;
		base = (radix_shadow < BASE_LO) ? BASE_LO :
			(radix_shadow > BASE_HI) ? BASE_HI : radix_shadow;
		case ($urandom_range(0, 5))
			0, 1: return VW'($urandom);
			2: return VW'($urandom_range(0, base * base));
			3: begin
				// near a power of the base, where the digit count steps
				p = 1;
				k = $urandom_range(1, VW);
				repeat (k)
					if (p * base <= {VW{1'b1}})
						p = p * base;
				return $urandom_range(0, 1) ? VW'(p) : VW'(p - 1);
			end
			4: return VW'($urandom >> $urandom_range(1, 31));
			default: return $urandom_range(0, 1) ? {VW{1'b1}} : '0;
		endcase
	endfunction

	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	task automatic apb_access(input bit wr, input logic [AW-1:0] addr,
			input logic [DW-1:0] data, output logic [DW-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (wr && addr == ADDR_RADIX)
			radix_shadow = data[5:0];
	endtask

	// write the radix register, then read it back
	task automatic set_radix(input logic [AW-1:0] addr, input logic [DW-1:0] data);
		logic [DW-1:0] rd;
		apb_access(1'b1, addr, data, rd);
		radix_writes++;
		apb_access(1'b0, ADDR_RADIX, '0, rd);
		if (rd[5:0] !== radix_shadow)
			flag_mismatch($sformatf("radix readback exp %0d got %0d", radix_shadow, rd[5:0]));
	endtask

	// one input beat; in_valid stays high after acceptance until the next gap or settle
	task automatic push_value(input logic [VW-1:0] v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		do @(posedge clk); while (in_stall);
		predict_digits(v);
		values_sent++;
	endtask

	// drain everything before touching the register
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_digits.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_reset_radix();
		logic [DW-1:0] rd;
		apb_access(1'b0, ADDR_RADIX, '0, rd);
		if (rd[5:0] !== 6'd2)
			flag_mismatch($sformatf("reset radix exp 2 got %0d", rd[5:0]));
		push_value('0);
		push_value(VW'(1));
		push_value({VW{1'b1}});
		push_value(VW'({(VW+1)/2{2'b01}}));
		push_value(VW'({(VW+1)/2{2'b10}}));
		settle();
	endtask

	task automatic test_radix_extremes();
		set_radix(ADDR_RADIX, 32'd0);
		push_value(VW'(5));
		push_value(VW'(6));
		settle();
		set_radix(ADDR_RADIX, 32'd1);
		push_value(VW'(5));
		settle();
		set_radix(ADDR_RADIX, 32'd36);
		push_value(VW'(35));
		push_value({VW{1'b1}});
		push_value(VW'(36 * 36 - 1));
		settle();
		set_radix(ADDR_RADIX, 32'd37);
		push_value(VW'(35));
		settle();
		set_radix(ADDR_RADIX, 32'd63);
		push_value(VW'(36 * 36));
		settle();
		// upper data bits are dropped by the register
		set_radix(ADDR_RADIX, 32'hFFFF_FFCA);
		push_value({VW{1'b1}});
		push_value(VW'(9));
		push_value(VW'(10));
		push_value('0);
		settle();
		set_radix(ADDR_RADIX, 32'd16);
		push_value(VW'(32'h0DEA_DBEF));
		settle();
	endtask

	task automatic test_spare_register();
		logic [DW-1:0] rd;
		logic [5:0]    before_write;
		before_write = radix_shadow;
		apb_access(1'b1, ADDR_SPARE, 32'd7, rd);
		apb_access(1'b0, ADDR_RADIX, '0, rd);
		if (rd[5:0] !== before_write)
			flag_mismatch($sformatf("spare write changed radix to %0d", rd[5:0]));
		push_value(VW'(255));
		settle();
	endtask

	task automatic test_random_values();
		logic [DW-1:0] word;
		for (int phase = 0; phase < 10; phase++) begin
			word = $urandom;
			case (phase)
				0: word[5:0] = 6'd2;
				1: word[5:0] = 6'd36;
				2: word[5:0] = 6'd63;
				3: word[5:0] = 6'd0;
				default:
					if ($urandom_range(0, 9) < 7)
						word[5:0] = 6'($urandom_range(BASE_LO, BASE_HI));
			endcase
			set_radix(ADDR_RADIX, word);
			// some phases run with no gaps or stalls at all
			idle_on = !(phase == 5 || phase == 8);
			repeat (25)
				push_value(pick_value());
			settle();
		end
		idle_on = 1'b1;
	endtask

	// output stall pattern, runs of stall and no stall
	always @(posedge clk) begin
		if (hold_left == 0) begin
			hold_stall = idle_on && $urandom_range(0, 2) == 0;
			hold_left = hold_stall ? 1 + pick_gap() : $urandom_range(1, 8);
		end
		hold_left--;
		out_stall <= hold_stall;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			beats_checked++;
			if (pending_digits.size() == 0) begin
				flag_mismatch($sformatf("unexpected beat char %0h last %0b",
					digit_char, last_digit));
			end else begin
				want = pending_digits.pop_front();
				if (digit_char !== want.ch)
					flag_mismatch($sformatf("digit_char exp %0h got %0h", want.ch, digit_char));
				if (last_digit !== want.last)
					flag_mismatch($sformatf("last_digit exp %0b got %0b", want.last, last_digit));
			end
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("watchdog: no beat for %0d cycles, %0d digits pending",
			QUIET_LIMIT, pending_digits.size());
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		value <= '0;
		radix_shadow = 6'd2;
		idle_on = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_radix();
		test_radix_extremes();
		test_spare_register();
		test_random_values();

		settle();
		repeat (40) @(posedge clk);
		$display("converted %0d values into %0d checked digit beats", values_sent, beats_checked);
		$display("radix register set %0d times, including 0, 1, 36, 37 and 63", radix_writes);
		if (mismatches == 0 && pending_digits.size() == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches, %0d digits never arrived", mismatches,
				pending_digits.size());
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/rdc_pkg.sv
rtl/rdc_divider.sv
rtl/rdc_digit_stack.sv
rtl/radix_digit_converter.sv
tb/tb.sv
